// ----- design/size_class_block_allocator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scba assertion failed");

// next-cycle implication
`define SCBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scba assertion failed");

`else

`define SCBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/scba_pkg.sv -----
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Shared widths, codes, payload and command types.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int ADDR_W          = 14;
  localparam int POOL_W          = 15;
  localparam int SIZE_W          = 10;
  localparam int CLASS_SHIFT     = 4;
  localparam int CLS_FW          = SIZE_W - CLASS_SHIFT;
  localparam int SLOT_W          = ADDR_W - 1;
  localparam int STORE_DEPTH     = 1 << SLOT_W;
  localparam int NEED_W          = 11;

  localparam int NUM_CLASSES_DEF = 32;
  localparam int POOL_MAX_BYTES  = 16384;
  localparam int HEADER_BYTES    = 2;
  localparam int ADDR_SPACE      = 1 << ADDR_W;
  localparam int LIMIT_CAP       = (POOL_MAX_BYTES < ADDR_SPACE) ? POOL_MAX_BYTES : ADDR_SPACE;
  localparam int POOL_RST        = 16384;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAG,
    S_FCLS,
    S_ACLS,
    S_LINK,
    S_DONE
  } scba_state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0] free_address;
  } scba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
  } scba_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
  } cls_ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [CLS_FW-1:0] rd_idx;
    logic              wr_en;
    logic [CLS_FW-1:0] wr_idx;
    cls_ent_t          wr_ent;
    logic              set_ne;
    logic              clr_ne;
    logic [CLS_FW-1:0] ne_idx;
    logic              clr_all;
  } cls_cmd_t;

  typedef struct packed {
    logic              link_rd;
    logic [SLOT_W-1:0] link_rd_slot;
    logic              link_wr;
    logic [SLOT_W-1:0] link_wr_slot;
    logic [ADDR_W-1:0] link_wr_data;
    logic              tag_rd;
    logic [SLOT_W-1:0] tag_rd_slot;
    logic              tag_wr;
    logic [SLOT_W-1:0] tag_wr_slot;
    logic [CLS_FW-1:0] tag_wr_data;
  } blk_cmd_t;

endpackage

// ----- design/scba_class_tbl.sv -----
// ----------------------------------------------------------------------------
// Class table
// Head/tail memory per size class plus a nonempty flag register per class.
// ----------------------------------------------------------------------------
module scba_class_tbl
  import scba_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cls_cmd_t cmd,
  output cls_ent_t rd_ent,
  output logic     rd_ne
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  cls_ent_t               ent_mem [NUM_CLASSES];
  cls_ent_t               rd_ent_r;
  logic [CLS_W-1:0]       rd_idx_r;
  logic [NUM_CLASSES-1:0] ne_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      ent_mem[cmd.wr_idx[CLS_W-1:0]] <= cmd.wr_ent;
    end
    if (cmd.rd_en) begin
      rd_ent_r <= ent_mem[cmd.rd_idx[CLS_W-1:0]];
      rd_idx_r <= cmd.rd_idx[CLS_W-1:0];
    end
  end

  // flags act as valid bits: head/tail are only used while the flag is set
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) begin
      ne_r <= '0;
    end else begin
      if (cmd.set_ne) ne_r[cmd.ne_idx[CLS_W-1:0]] <= 1'b1;
      if (cmd.clr_ne) ne_r[cmd.ne_idx[CLS_W-1:0]] <= 1'b0;
    end
  end

  assign rd_ent = rd_ent_r;
  assign rd_ne  = ne_r[rd_idx_r];

`include "size_class_block_allocator_core_assert.svh"

  `SCBA_ASSERT_IMP(a_ne_excl, clk, rst_n, cmd.set_ne, !cmd.clr_ne)
  `SCBA_ASSERT_IMP(a_clr_quiet, clk, rst_n, cmd.clr_all, !cmd.wr_en && !cmd.set_ne)
  `SCBA_ASSERT_NXT(a_clr_empty, clk, rst_n, cmd.clr_all, ne_r == '0)

endmodule

// ----- design/scba_blk_store.sv -----
// ----------------------------------------------------------------------------
// Block store
// Per-block link memory and class tag memory, indexed by block address / 2.
// ----------------------------------------------------------------------------
module scba_blk_store
  import scba_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic              clk,
  input  blk_cmd_t          cmd,
  output logic [ADDR_W-1:0] link_q,
  output logic [CLS_FW-1:0] tag_q
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [ADDR_W-1:0] link_mem [STORE_DEPTH];
  logic [CLS_W-1:0]  tag_mem  [STORE_DEPTH];
  logic [ADDR_W-1:0] link_q_r;
  logic [CLS_W-1:0]  tag_q_r;

  always_ff @(posedge clk) begin
    if (cmd.link_wr) begin
      link_mem[cmd.link_wr_slot] <= cmd.link_wr_data;
    end
    if (cmd.link_rd) begin
      link_q_r <= link_mem[cmd.link_rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tag_wr) begin
      tag_mem[cmd.tag_wr_slot] <= cmd.tag_wr_data[CLS_W-1:0];
    end
    if (cmd.tag_rd) begin
      tag_q_r <= tag_mem[cmd.tag_rd_slot];
    end
  end

  assign link_q = link_q_r;
  assign tag_q  = CLS_FW'(tag_q_r);

endmodule

// ----- design/size_class_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Size-class block allocator core
// Segregated FIFO free lists over a byte pool with a bump pointer fallback.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request (mode, alloc_size, free_address) per valid/stall
//           handshake; in_stall is high while a request is in flight.
//   out_* : one response (result_address, status) per request, held in an
//           output register until taken; out_stall holds it in place.
//   cfg_* : pool_bytes, written while no request is in flight.
// States between accept and DONE, which loads the output register:
//   clear, unused mode, oversized alloc : none
//   alloc from pool, alloc last of list  : ACLS
//   alloc with list remaining, free      : ACLS, LINK / TAG, FCLS
// One request at a time; the next is taken in the cycle after the response
// enters the output register. The chain of synchronous reads (class table,
// then link memory on alloc, tag memory then class table on free) sets the path.
// A stalled receiver holds the response in the output register and the
// core waits for it to free before finishing the next request.
// Reset empties all lists and the pool; pool_bytes returns to 16384.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core
  import scba_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  scba_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output scba_out_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [POOL_W-1:0] cfg_wr_data
);

  scba_state_t       state_r, state_nxt;
  logic [CLS_FW-1:0] cls_r, cls_nxt;
  logic [ADDR_W-1:0] blk_r, blk_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [CLS_FW-1:0] tag_r, tag_nxt;
  logic [POOL_W-1:0] pool_top_r, pool_top_nxt;
  logic [POOL_W-1:0] pool_bytes_r;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  scba_out_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  cls_cmd_t          cls_cmd;
  cls_ent_t          cls_q;
  logic              cls_ne;
  blk_cmd_t          blk_cmd;
  logic [ADDR_W-1:0] link_q;
  logic [CLS_FW-1:0] tag_q;

  logic              accept;
  logic [CLS_FW-1:0] in_cls;
  logic [ADDR_W-1:0] in_blk;
  logic              in_cls_ok;
  logic              tag_ok;
  logic              out_free;
  logic [POOL_W-1:0] limit;
  logic [POOL_W:0]   pool_sum;
  logic              fits;
  logic              more_in_list;

  scba_class_tbl #(.NUM_CLASSES(NUM_CLASSES)) u_class_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cls_cmd),
    .rd_ent (cls_q),
    .rd_ne  (cls_ne)
  );

  scba_blk_store #(.NUM_CLASSES(NUM_CLASSES)) u_blk_store (
    .clk    (clk),
    .cmd    (blk_cmd),
    .link_q (link_q),
    .tag_q  (tag_q)
  );

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign in_cls       = in_data.alloc_size[SIZE_W-1:CLASS_SHIFT];
  assign in_blk       = in_data.free_address - ADDR_W'(HEADER_BYTES);
  assign in_cls_ok    = {1'b0, in_cls} < (CLS_FW+1)'(NUM_CLASSES);
  assign tag_ok       = {1'b0, tag_q} < (CLS_FW+1)'(NUM_CLASSES);
  assign out_free     = !out_valid_r || !out_stall;
  assign limit        = (pool_bytes_r > POOL_W'(LIMIT_CAP)) ? POOL_W'(LIMIT_CAP) : pool_bytes_r;
  assign pool_sum     = {1'b0, pool_top_r} + (POOL_W+1)'(need_r);
  assign fits         = pool_sum <= {1'b0, limit};
  assign more_in_list = cls_ne && (cls_q.head != cls_q.tail);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_ALLOC: state_nxt = in_cls_ok ? S_ACLS : S_DONE;
            MODE_FREE:  state_nxt = S_TAG;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_TAG:   state_nxt = tag_ok ? S_FCLS : S_DONE;
      S_FCLS:  state_nxt = S_DONE;
      S_ACLS:  state_nxt = more_in_list ? S_LINK : S_DONE;
      S_LINK:  state_nxt = S_DONE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory commands and datapath
  always_comb begin
    cls_cmd       = '0;
    blk_cmd       = '0;
    cls_nxt       = cls_r;
    blk_nxt       = blk_r;
    need_nxt      = need_r;
    tag_nxt       = tag_r;
    pool_top_nxt  = pool_top_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cls_nxt      = in_cls;
          blk_nxt      = in_blk;
          need_nxt     = (NEED_W'(in_cls) + NEED_W'(1)) << CLASS_SHIFT;
          need_nxt     = need_nxt + NEED_W'(HEADER_BYTES);
          res_addr_nxt = '0;
          res_st_nxt   = STAT_OK;
          case (in_data.mode)
            MODE_ALLOC: begin
              if (in_cls_ok) begin
                cls_cmd.rd_en  = 1'b1;
                cls_cmd.rd_idx = in_cls;
              end else begin
                res_st_nxt = STAT_TOO_LARGE;
              end
            end
            MODE_FREE: begin
              blk_cmd.tag_rd      = 1'b1;
              blk_cmd.tag_rd_slot = in_blk[ADDR_W-1:1];
            end
            MODE_CLEAR: begin
              cls_cmd.clr_all = 1'b1;
              pool_top_nxt    = '0;
            end
            default: ;
          endcase
        end
      end

      S_TAG: begin
        tag_nxt = tag_q;
        if (tag_ok) begin
          cls_cmd.rd_en  = 1'b1;
          cls_cmd.rd_idx = tag_q;
        end
      end

      // append freed block at the tail
      S_FCLS: begin
        cls_cmd.wr_en       = 1'b1;
        cls_cmd.wr_idx      = tag_r;
        cls_cmd.wr_ent.tail = blk_r;
        if (cls_ne) begin
          blk_cmd.link_wr      = 1'b1;
          blk_cmd.link_wr_slot = cls_q.tail[ADDR_W-1:1];
          blk_cmd.link_wr_data = blk_r;
          cls_cmd.wr_ent.head  = cls_q.head;
        end else begin
          cls_cmd.wr_ent.head = blk_r;
          cls_cmd.set_ne      = 1'b1;
          cls_cmd.ne_idx      = tag_r;
        end
      end

      S_ACLS: begin
        if (cls_ne) begin
          blk_cmd.tag_wr      = 1'b1;
          blk_cmd.tag_wr_slot = cls_q.head[ADDR_W-1:1];
          blk_cmd.tag_wr_data = cls_r;
          res_addr_nxt        = cls_q.head + ADDR_W'(HEADER_BYTES);
          if (more_in_list) begin
            blk_cmd.link_rd      = 1'b1;
            blk_cmd.link_rd_slot = cls_q.head[ADDR_W-1:1];
          end else begin
            cls_cmd.clr_ne = 1'b1;
            cls_cmd.ne_idx = cls_r;
          end
        end else if (fits) begin
          pool_top_nxt        = pool_sum[POOL_W-1:0];
          blk_cmd.tag_wr      = 1'b1;
          blk_cmd.tag_wr_slot = pool_top_r[ADDR_W-1:1];
          blk_cmd.tag_wr_data = cls_r;
          res_addr_nxt        = pool_top_r[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
        end else begin
          res_st_nxt = STAT_EXHAUSTED;
        end
      end

      // advance head to the popped block's successor
      S_LINK: begin
        cls_cmd.wr_en       = 1'b1;
        cls_cmd.wr_idx      = cls_r;
        cls_cmd.wr_ent.head = link_q;
        cls_cmd.wr_ent.tail = cls_q.tail;
      end

      S_DONE: begin
        if (out_free) begin
          out_nxt.result_address = res_addr_r;
          out_nxt.status         = res_st_r;
          out_valid_nxt          = 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pool_top_r   <= '0;
      pool_bytes_r <= POOL_W'(POOL_RST);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pool_top_r  <= pool_top_nxt;
      if (cfg_wr_en) begin
        pool_bytes_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cls_r      <= cls_nxt;
    blk_r      <= blk_nxt;
    need_r     <= need_nxt;
    tag_r      <= tag_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "size_class_block_allocator_core_assert.svh"

  `SCBA_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE))
  `SCBA_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE)
  `SCBA_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid_r && (out_r.status != STAT_OK),
                   out_r.result_address == '0)
  `SCBA_ASSERT_IMP(a_pool_cap, clk, rst_n, 1'b1, pool_top_r <= POOL_W'(LIMIT_CAP))

endmodule

// ----- verif/size_class_block_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class block allocator core testbench
// A table of directed requests, then random request mixes under several
// pool sizes. Each response is compared with the table's expected value or
// with a behavioral model of the segregated free lists and the bump pointer.
// Requests come in bursts and the response side stalls at a changing rate.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core_test;
  import scba_pkg::*;

  localparam int N_CLS = NUM_CLASSES_DEF;
  localparam int CLASS_BYTES = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_REQUESTS = 100;
  localparam int RECENT_DEPTH = 8;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic              is_cfg;
    logic [POOL_W-1:0] cfg_val;
    scba_in_t          req;
    logic              typed;
    scba_out_t         want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  scba_in_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  scba_out_t         out_data;
  logic              cfg_wr_en = 1'b0;
  logic [POOL_W-1:0] cfg_wr_data = '0;

  // allocator model state
  logic [POOL_W-1:0] pool_bytes_cfg = POOL_W'(POOL_RST);
  logic [POOL_W-1:0] bump_top = '0;
  bit                list_nonempty [N_CLS];
  logic [ADDR_W-1:0] list_head [N_CLS];
  logic [ADDR_W-1:0] list_tail [N_CLS];
  logic [ADDR_W-1:0] link_mem [STORE_DEPTH];
  logic [CLS_FW-1:0] tag_mem [STORE_DEPTH];
  bit                link_known [STORE_DEPTH];
  bit                tag_known [STORE_DEPTH];

  // address bookkeeping for request generation
  logic [ADDR_W-1:0] live_addrs [$];
  logic [ADDR_W-1:0] freed_recent [$];
  logic [SLOT_W-1:0] tagged_slots [$];

  scba_out_t awaited_responses [$];
  dir_row_t  dir_tbl [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b1;
  int        stall_pct = 0;
  int        stall_age = 0;

  size_class_block_allocator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Applies one request to the model and returns the response it gives.
  function automatic scba_out_t predict_response(input scba_in_t req);
    scba_out_t         resp;
    logic [CLS_FW-1:0] cls;
    logic [ADDR_W-1:0] blk;
    logic [SLOT_W-1:0] slot;
    int                need;
    int                limit;
    bit                grant;
    resp.result_address = '0;
    resp.status = STAT_OK;
    grant = 1'b0;
    blk = '0;
    cls = req.alloc_size[SIZE_W-1:CLASS_SHIFT];
    case (req.mode)
      MODE_ALLOC: begin
        if (int'(cls) >= N_CLS) begin
          resp.status = STAT_TOO_LARGE;
        end else if (list_nonempty[cls]) begin
          blk = list_head[cls];
          grant = 1'b1;
          if (blk == list_tail[cls]) list_nonempty[cls] = 1'b0;
          else list_head[cls] = link_mem[blk[ADDR_W-1:1]];
        end else begin
          need = (int'(cls) + 1) * CLASS_BYTES + HEADER_BYTES;
          limit = int'(pool_bytes_cfg);
          if (limit > POOL_MAX_BYTES) limit = POOL_MAX_BYTES;
          if (limit > ADDR_SPACE) limit = ADDR_SPACE;
          if (int'(bump_top) + need > limit) begin
            resp.status = STAT_EXHAUSTED;
          end else begin
            blk = bump_top[ADDR_W-1:0];
            bump_top = bump_top + POOL_W'(need);
            grant = 1'b1;
          end
        end
        if (grant) begin
          slot = blk[ADDR_W-1:1];
          if (!tag_known[slot]) begin
            tag_known[slot] = 1'b1;
            tagged_slots.push_back(slot);
          end
          tag_mem[slot] = cls;
          resp.result_address = blk + ADDR_W'(HEADER_BYTES);
          live_addrs.push_back(resp.result_address);
        end
      end
      MODE_FREE: begin
        blk = req.free_address - ADDR_W'(HEADER_BYTES);
        cls = tag_mem[blk[ADDR_W-1:1]];
        freed_recent.push_back(req.free_address);
        if (freed_recent.size() > RECENT_DEPTH) void'(freed_recent.pop_front());
        if (int'(cls) < N_CLS) begin
          if (list_nonempty[cls]) begin
            link_mem[list_tail[cls][ADDR_W-1:1]] = blk;
            link_known[list_tail[cls][ADDR_W-1:1]] = 1'b1;
            list_tail[cls] = blk;
          end else begin
            list_head[cls] = blk;
            list_tail[cls] = blk;
            list_nonempty[cls] = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        foreach (list_nonempty[i]) list_nonempty[i] = 1'b0;
        bump_top = '0;
        live_addrs.delete();
      end
      default: ;
    endcase
    return resp;
  endfunction

  // Tag and link entries are undefined until written; requests that would
  // read one are never sent.
  function automatic bit touches_unwritten(input scba_in_t req);
    logic [CLS_FW-1:0] cls;
    logic [ADDR_W-1:0] blk;
    cls = req.alloc_size[SIZE_W-1:CLASS_SHIFT];
    blk = req.free_address - ADDR_W'(HEADER_BYTES);
    if (req.mode == MODE_FREE) return !tag_known[blk[ADDR_W-1:1]];
    if (req.mode == MODE_ALLOC && int'(cls) < N_CLS && list_nonempty[cls] &&
        list_head[cls] != list_tail[cls])
      return !link_known[list_head[cls][ADDR_W-1:1]];
    return 1'b0;
  endfunction

  function automatic scba_in_t make_request();
    scba_in_t          req;
    int                r;
    int                pick;
    int                idx;
    logic [SLOT_W-1:0] s;
    req.mode = MODE_ALLOC;
    req.alloc_size = SIZE_W'($urandom);
    req.free_address = ADDR_W'($urandom);
    r = $urandom_range(99);
    pick = $urandom_range(99);
    if (r < 45 || r >= 88) begin
      // mostly small classes so the pool lasts a while
      if (pick < 80) req.alloc_size = SIZE_W'($urandom_range(127));
      else if (pick < 92) req.alloc_size = SIZE_W'($urandom_range(511, 128));
      else req.alloc_size = SIZE_W'($urandom_range(1023, 512));
    end else if (r < 80) begin
      req.mode = MODE_FREE;
      if (live_addrs.size() != 0 && pick < 70) begin
        idx = $urandom_range(live_addrs.size() - 1);
        req.free_address = live_addrs[idx];
        live_addrs.delete(idx);
      end else if (freed_recent.size() != 0 && pick < 85) begin
        // double free
        req.free_address = freed_recent[$urandom_range(freed_recent.size() - 1)];
      end else if (tagged_slots.size() != 0) begin
        // any tagged slot, odd or even block address
        s = tagged_slots[$urandom_range(tagged_slots.size() - 1)];
        req.free_address = {s, 1'($urandom)} + ADDR_W'(HEADER_BYTES);
      end else begin
        req.mode = MODE_ALLOC;
      end
    end else if (r < 84) begin
      req.mode = MODE_CLEAR;
    end else begin
      req.mode = MODE_RESERVED;
    end
    if (touches_unwritten(req)) req.mode = MODE_CLEAR;
    return req;
  endfunction

  function automatic dir_row_t req_row(input logic [1:0] mode, input int size,
                                       input int faddr);
    dir_row_t row;
    row = '0;
    row.req.mode = mode;
    row.req.alloc_size = SIZE_W'(size);
    row.req.free_address = ADDR_W'(faddr);
    return row;
  endfunction

  function automatic dir_row_t known_row(input logic [1:0] mode, input int size,
                                         input int faddr, input int addr,
                                         input logic [1:0] status);
    dir_row_t row;
    row = req_row(mode, size, faddr);
    row.typed = 1'b1;
    row.want.result_address = ADDR_W'(addr);
    row.want.status = status;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input int val);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_val = POOL_W'(val);
    return row;
  endfunction

  // Bursts of requests, with random gaps in between while gaps_on is set.
  task automatic sender_gap();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if (gaps_on) begin
        gap = $urandom_range(8, 1);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic issue_request(input scba_in_t req, input logic typed,
                               input scba_out_t want);
    scba_out_t predicted;
    sender_gap();
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_response(req);
    awaited_responses.push_back(typed ? want : predicted);
  endtask

  task automatic write_pool_bytes(input logic [POOL_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_bytes_cfg = val;
  endtask

  // response side: stall rate is picked anew from 0, 25, 50 or 90 percent each time stall_age wraps
  always @(posedge clk) begin
    stall_age++;
    if (stall_age == 64) begin
      stall_age = 0;
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 90;
      endcase
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    scba_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch($sformatf("response with none pending: addr %0d status %0d",
                                    out_data.result_address, out_data.status));
        end else begin
          want = awaited_responses.pop_front();
          if (out_data.result_address !== want.result_address)
            report_mismatch($sformatf("result_address got %0d want %0d",
                                      out_data.result_address, want.result_address));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
          $display("** size_class_block_allocator_core: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned phase_pool [5];
    int unsigned pool_val;
    phase_pool = '{16384, 16, 1000, 0, 16384};

    dir_tbl.push_back(known_row(MODE_ALLOC, 0, 0, 2, STAT_OK));
    dir_tbl.push_back(known_row(MODE_ALLOC, 15, 16383, 20, STAT_OK));
    dir_tbl.push_back(known_row(MODE_ALLOC, 511, 'h2AAA, 38, STAT_OK));
    dir_tbl.push_back(known_row(MODE_ALLOC, 512, 0, 0, STAT_TOO_LARGE));
    dir_tbl.push_back(known_row(MODE_ALLOC, 1023, 16383, 0, STAT_TOO_LARGE));
    dir_tbl.push_back(known_row(MODE_FREE, 1023, 2, 0, STAT_OK));
    dir_tbl.push_back(known_row(MODE_FREE, 0, 20, 0, STAT_OK));
    dir_tbl.push_back(known_row(MODE_FREE, 'h155, 20, 0, STAT_OK));
    dir_tbl.push_back(req_row(MODE_ALLOC, 5, 0));
    dir_tbl.push_back(req_row(MODE_ALLOC, 7, 0));
    dir_tbl.push_back(req_row(MODE_ALLOC, 0, 0));
    dir_tbl.push_back(known_row(MODE_RESERVED, 1023, 16383, 0, STAT_OK));
    dir_tbl.push_back(known_row(MODE_FREE, 0, 38, 0, STAT_OK));
    dir_tbl.push_back(req_row(MODE_ALLOC, 500, 0));
    dir_tbl.push_back(known_row(MODE_CLEAR, 1023, 16383, 0, STAT_OK));
    dir_tbl.push_back(req_row(MODE_ALLOC, 100, 0));
    // odd address: block sits one byte into a tagged slot
    dir_tbl.push_back(known_row(MODE_FREE, 0, 3, 0, STAT_OK));
    dir_tbl.push_back(req_row(MODE_ALLOC, 96, 0));
    dir_tbl.push_back(cfg_row(16));
    dir_tbl.push_back(known_row(MODE_CLEAR, 0, 0, 0, STAT_OK));
    dir_tbl.push_back(known_row(MODE_ALLOC, 0, 0, 0, STAT_EXHAUSTED));
    // exact fit, then one past it
    dir_tbl.push_back(cfg_row(18));
    dir_tbl.push_back(known_row(MODE_ALLOC, 0, 0, 2, STAT_OK));
    dir_tbl.push_back(known_row(MODE_ALLOC, 0, 0, 0, STAT_EXHAUSTED));
    dir_tbl.push_back(known_row(MODE_ALLOC, 600, 0, 0, STAT_TOO_LARGE));
    dir_tbl.push_back(cfg_row(16384));
    dir_tbl.push_back(known_row(MODE_CLEAR, 0, 0, 0, STAT_OK));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_pool_bytes(dir_tbl[i].cfg_val);
      else issue_request(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);
    end

    foreach (phase_pool[p]) begin
      pool_val = (phase_pool[p] == 0) ? $urandom_range(16384, 16) : phase_pool[p];
      write_pool_bytes(POOL_W'(pool_val));
      gaps_on = ($urandom_range(3) != 0);
      repeat (PHASE_REQUESTS) issue_request(make_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** size_class_block_allocator_core: PASSED **");
    end else begin
      $display("** size_class_block_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
